>>> rtl/fdma_pkg.sv
// Shared constants and types for the frame delta moving average block.
// No dependencies; imported by frame_delta_moving_average, fdma_checker and the testbench.
`default_nettype none

package fdma_pkg;

  // Width of stamps, deltas, sums and averages
  localparam int STAMP_W = 64;

  // Default depth of the delta ring
  localparam int RING_DEPTH_DEF = 16;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_DIV,
    ST_DONE
  } fdma_state_t;

endpackage

`default_nettype wire

>>> rtl/frame_delta_moving_average.sv
// Frame delta moving average: stamp deltas, a ring of recent deltas, a mean.
// Depends on fdma_pkg for widths and the sequencer state type.
//
// Sequence: an accepted stamp goes through ST_READ (ring update), ST_ADD (sum
//   update), the 64-step restoring divider in ST_DIV, and ST_DONE into the
//   output register; the first stamp after reset skips ring and divider.
// One stamp at a time: in_stall stays high until ST_DONE hands on the result.
// Reset (rst_n low, synchronous): not started, ring empty, sum and held
//   average zero. Ring contents are not cleared; entries are read only once
//   written.
`default_nettype none

module frame_delta_moving_average #(
  parameter int RING_DEPTH = fdma_pkg::RING_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // stamp channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fdma_pkg::STAMP_W-1:0] in_timestamp_ns,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fdma_pkg::STAMP_W-1:0]      out_delta_ns,
  output logic [fdma_pkg::STAMP_W-1:0]      out_average_ns,
  output logic                              out_first_stamp
);

  import fdma_pkg::*;

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int STEP_W = $clog2(STAMP_W);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(RING_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STAMP_W - 1);

  // ring memory and its registered read port
  logic [STAMP_W-1:0] ring_mem [RING_DEPTH];
  logic [STAMP_W-1:0] ring_rd_r;
  logic               ring_we;

  fdma_state_t        state_r, state_nxt;
  logic               started_r, started_nxt;
  logic [STAMP_W-1:0] prev_r, prev_nxt;
  logic [STAMP_W-1:0] delta_r, delta_nxt;
  logic               first_r, first_nxt;
  logic [PTR_W-1:0]   wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [STAMP_W-1:0] sum_r, sum_nxt;
  logic [STAMP_W-1:0] held_avg_r, held_avg_nxt;
  logic [STAMP_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAMP_W-1:0] out_delta_r, out_delta_nxt;
  logic [STAMP_W-1:0] out_avg_r, out_avg_nxt;
  logic               out_first_r, out_first_nxt;

  logic               in_take;
  logic               out_free;
  logic               ring_full;
  logic [STAMP_W-1:0] sum_plus;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_diff;

  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign ring_full = (fill_r == CNT_FULL);
  assign sum_plus  = sum_r + delta_r;
  assign rem_sh    = {rem_r, quo_r[STAMP_W-1]};
  assign rem_diff  = rem_sh - {1'b0, fill_r};

  // next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = started_r ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory strobes
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ring_we  = (state_r == ST_READ);
  end

  // datapath next values
  always_comb begin
    started_nxt   = started_r;
    prev_nxt      = prev_r;
    delta_nxt     = delta_r;
    first_nxt     = first_r;
    wr_pos_nxt    = wr_pos_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    held_avg_nxt  = held_avg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_delta_nxt = out_delta_r;
    out_avg_nxt   = out_avg_r;
    out_first_nxt = out_first_r;

    unique case (state_r)
      // take the stamp, form the modular delta
      ST_IDLE: begin
        if (in_take) begin
          started_nxt = 1'b1;
          prev_nxt    = in_timestamp_ns;
          first_nxt   = !started_r;
          delta_nxt   = started_r ? (in_timestamp_ns - prev_r) : '0;
        end
      end
      // drop the overwritten entry from the sum, advance the ring
      ST_READ: begin
        if (ring_full) begin
          sum_nxt = sum_r - ring_rd_r;
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        wr_pos_nxt = (wr_pos_r == PTR_LAST) ? '0 : wr_pos_r + PTR_W'(1);
      end
      // add the new delta, load the divider
      ST_ADD: begin
        sum_nxt  = sum_plus;
        quo_nxt  = sum_plus;
        rem_nxt  = '0;
        step_nxt = '0;
      end
      // one restoring divide step per cycle
      ST_DIV: begin
        if (!rem_diff[CNT_W]) begin
          rem_nxt = rem_diff[CNT_W-1:0];
          quo_nxt = {quo_r[STAMP_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CNT_W-1:0];
          quo_nxt = {quo_r[STAMP_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
      end
      // hand the result beat to the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_delta_nxt = delta_r;
          out_first_nxt = first_r;
          out_avg_nxt   = first_r ? held_avg_r : quo_r;
          if (!first_r) begin
            held_avg_nxt = quo_r;
          end
        end
      end
      default: ;
    endcase
  end

  // ring memory: write the delta, read at the write position
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_pos_r] <= delta_r;
    end
    ring_rd_r <= ring_mem[wr_pos_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      prev_r      <= '0;
      wr_pos_r    <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      held_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      prev_r      <= prev_nxt;
      wr_pos_r    <= wr_pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      held_avg_r  <= held_avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    delta_r     <= delta_nxt;
    first_r     <= first_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    out_delta_r <= out_delta_nxt;
    out_avg_r   <= out_avg_nxt;
    out_first_r <= out_first_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_delta_ns    = out_delta_r;
  assign out_average_ns  = out_avg_r;
  assign out_first_stamp = out_first_r;

endmodule

`default_nettype wire

>>> test/fdma_checker.sv
// Scoreboard for frame_delta_moving_average: watches the stamp and result channels,
// predicts every result beat and compares it field by field.
// Depends on fdma_pkg for the stamp width and the default ring depth.
module fdma_checker #(
  parameter int RING_DEPTH = fdma_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [fdma_pkg::STAMP_W-1:0] in_timestamp_ns,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [fdma_pkg::STAMP_W-1:0] out_delta_ns,
  input  logic [fdma_pkg::STAMP_W-1:0] out_average_ns,
  input  logic                         out_first_stamp,
  input  logic                         run_done,
  output int                           mismatches,
  output int                           outstanding,
  output int                           results_seen,
  output int                           sum_wraps
);
  timeunit 1ns;
  timeprecision 1ps;

  import fdma_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    stamp_t delta;
    stamp_t average;
    logic   first;
  } frame_result_t;

  // Shadow state of the averaging block
  stamp_t      prev_stamp;
  logic        armed;
  stamp_t      delta_hist [RING_DEPTH];
  int unsigned hist_wr_idx;
  int unsigned hist_fill;
  stamp_t      delta_sum;
  stamp_t      held_avg;

  frame_result_t awaited_frame_results [$];
  logic          leftovers_checked;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    sum_wraps    = 0;
  end

  // Print one line (up to a cap) and count the failure
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // Advance the shadow state by one stamp and return the result it causes
  function automatic frame_result_t predict_frame_average(input stamp_t stamp);
    frame_result_t res;
    stamp_t        step;
    if (!armed) begin
      // first stamp only arms the timer
      armed      = 1'b1;
      prev_stamp = stamp;
      res.delta   = '0;
      res.average = held_avg;
      res.first   = 1'b1;
      return res;
    end
    step       = stamp - prev_stamp;
    prev_stamp = stamp;
    // drop the oldest delta once the history is full
    if (hist_fill == RING_DEPTH) delta_sum = delta_sum - delta_hist[hist_wr_idx];
    else hist_fill++;
    delta_hist[hist_wr_idx] = step;
    if (delta_sum + step < delta_sum) sum_wraps++;
    delta_sum   = delta_sum + step;
    hist_wr_idx = (hist_wr_idx + 1) % RING_DEPTH;
    held_avg    = delta_sum / stamp_t'(hist_fill);
    res.delta   = step;
    res.average = held_avg;
    res.first   = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      prev_stamp  = '0;
      armed       = 1'b0;
      hist_wr_idx = 0;
      hist_fill   = 0;
      delta_sum   = '0;
      held_avg    = '0;
      leftovers_checked = 1'b0;
      awaited_frame_results.delete();
    end else begin
      // compare the result beat before queueing a new stamp
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_frame_results.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with no stamp pending",
                                    results_seen));
        end else begin
          want = awaited_frame_results.pop_front();
          if (out_delta_ns !== want.delta)
            report_mismatch($sformatf("beat %0d delta_ns %h, predicted %h",
                                      results_seen, out_delta_ns, want.delta));
          if (out_average_ns !== want.average)
            report_mismatch($sformatf("beat %0d average_ns %h, predicted %h",
                                      results_seen, out_average_ns, want.average));
          if (out_first_stamp !== want.first)
            report_mismatch($sformatf("beat %0d first_stamp %b, predicted %b",
                                      results_seen, out_first_stamp, want.first));
        end
      end
      if (in_valid && !in_stall)
        awaited_frame_results.push_back(predict_frame_average(in_timestamp_ns));
      // flag anything still owed at the end of the run
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (awaited_frame_results.size() != 0)
          report_mismatch($sformatf("%0d predicted results never arrived",
                                    awaited_frame_results.size()));
      end
    end
    outstanding <= awaited_frame_results.size();
  end

endmodule

>>> test/testbench.sv
// Top of the frame_delta_moving_average testbench: clock, reset, stamp and stall
// generation, watchdog and verdict. Depends on fdma_pkg, the block and fdma_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdma_pkg::*;

  localparam int RING_DEPTH       = RING_DEPTH_DEF;
  localparam int RANDOM_STAMPS    = 1080;
  localparam int LONG_HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES     = 80;
  localparam int QUIET_LIMIT      = 5000;
  localparam logic [STAMP_W-1:0] FRAME_NS = 64'd16_666_667;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [STAMP_W-1:0] in_timestamp_ns = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [STAMP_W-1:0] out_delta_ns;
  logic [STAMP_W-1:0] out_average_ns;
  logic               out_first_stamp;
  logic               run_done        = 1'b0;
  logic               hold_request    = 1'b0;

  int mismatches;
  int outstanding;
  int results_seen;
  int sum_wraps;

  logic [STAMP_W-1:0] last_stamp;
  int unsigned        stamps_sent;
  int unsigned        odd_stamps;

  frame_delta_moving_average #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_ns (in_timestamp_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delta_ns    (out_delta_ns),
    .out_average_ns  (out_average_ns),
    .out_first_stamp (out_first_stamp)
  );

  fdma_checker #(.RING_DEPTH(RING_DEPTH)) scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_timestamp_ns (in_timestamp_ns),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delta_ns    (out_delta_ns),
    .out_average_ns  (out_average_ns),
    .out_first_stamp (out_first_stamp),
    .run_done        (run_done),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .sum_wraps       (sum_wraps)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one stamp beat and hold it until accepted
  task automatic offer_stamp(input logic [STAMP_W-1:0] stamp);
    in_valid        <= 1'b1;
    in_timestamp_ns <= stamp;
    do @(posedge clk); while (in_stall);
    last_stamp = stamp;
    stamps_sent++;
  endtask

  // Drop valid for a gap between bursts
  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Stamp source: directed edge cases, then bursts of random stamps
  initial begin : stamp_source
    logic [STAMP_W-1:0] stamp;
    int unsigned        burst_left;
    int unsigned        pick;
    stamps_sent = 0;
    odd_stamps  = 0;
    last_stamp  = '0;
    burst_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero first stamp, max delta, wrap back to zero, backward step, repeat
    offer_stamp('0);
    offer_stamp('1);
    offer_stamp('0);
    offer_stamp('1);
    offer_stamp(64'd1000);
    offer_stamp(64'd500);
    offer_stamp(64'd500);
    // steady frames push the huge deltas out of the full history
    for (int k = 1; k <= 15; k++) offer_stamp(64'd500 + 64'(k) * FRAME_NS);
    wait_results_drained();

    // receiver holds off for a long stretch while stamps keep coming
    hold_request <= 1'b1;
    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        stamp = last_stamp + FRAME_NS - 64'd800_000 + 64'($urandom_range(0, 1_600_000));
      end else if (pick < 70) begin
        stamp = last_stamp + 64'($urandom_range(0, 3));
      end else if (pick < 78) begin
        stamp = {$urandom, $urandom};
        odd_stamps++;
      end else if (pick < 86) begin
        stamp = last_stamp - 64'($urandom_range(1, 50_000_000));
        odd_stamps++;
      end else if (pick < 92) begin
        stamp = last_stamp + {1'b1, 31'($urandom), 32'($urandom)};
        odd_stamps++;
      end else begin
        stamp = '1 - 64'($urandom_range(0, 20_000_000));
        odd_stamps++;
      end
      // bursts of random length with random gaps, none during the long hold
      if (i >= 6) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 140));
        end
        burst_left--;
      end
      if (i == RANDOM_STAMPS / 2) wait_results_drained();
      offer_stamp(stamp);
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Run covered %0d stamps, %0d of them backward steps, timer wraps or wild jumps",
             stamps_sent, odd_stamps);
    $display("Checked %0d result beats; the running sum wrapped %0d times",
             results_seen, sum_wraps);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Result receiver: one long hold-off, otherwise segments of stall patterns
  initial begin : receiver_pattern
    int unsigned seg_left;
    int unsigned period;
    int unsigned phase;
    stall_mode_t seg_mode;
    bit          held;
    seg_left = 0;
    period   = 2;
    phase    = 0;
    seg_mode = STALL_NONE;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 400);
          seg_mode = stall_mode_t'($urandom_range(0, 3));
          period   = $urandom_range(2, 9);
          phase    = 0;
        end
        seg_left--;
        phase++;
        case (seg_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((phase % period) < period / 2);
        endcase
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
